// File: rtl/core/biq_pkg.sv
package biq_pkg;

  localparam int SAMPLE_BITS    = 24;
  localparam int COEF_FRAC_BITS = 24;
  localparam int COEF_W         = COEF_FRAC_BITS + 4;
  localparam int THRESH_W       = 8;
  localparam int CFG_IDX_W      = 3;
  localparam int PROD_W         = COEF_W + SAMPLE_BITS;
  // five products summed plus rounding need three guard bits
  localparam int ACC_W          = PROD_W + 3;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]      coef_t;
  typedef logic signed [PROD_W-1:0]      prod_t;
  typedef logic signed [ACC_W-1:0]       acc_t;
  typedef logic [THRESH_W-1:0]           thresh_t;
  typedef logic [CFG_IDX_W-1:0]          cfg_idx_t;

  // register indexes on the configuration channel
  localparam cfg_idx_t REG_B0     = CFG_IDX_W'(0);
  localparam cfg_idx_t REG_B1     = CFG_IDX_W'(1);
  localparam cfg_idx_t REG_B2     = CFG_IDX_W'(2);
  localparam cfg_idx_t REG_A1     = CFG_IDX_W'(3);
  localparam cfg_idx_t REG_A2     = CFG_IDX_W'(4);
  localparam cfg_idx_t REG_THRESH = CFG_IDX_W'(5);

  localparam coef_t COEF_ONE = coef_t'(64'sd1 <<< COEF_FRAC_BITS);

  localparam sample_t SAMPLE_MAX = sample_t'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam sample_t SAMPLE_MIN = sample_t'(-(64'sd1 <<< (SAMPLE_BITS - 1)));

  localparam acc_t ACC_SMAX   = acc_t'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam acc_t ACC_SMIN   = acc_t'(-(64'sd1 <<< (SAMPLE_BITS - 1)));
  localparam acc_t ROUND_HALF = acc_t'(64'sd1 <<< (COEF_FRAC_BITS - 1));

  typedef struct packed {
    coef_t   b0;
    coef_t   b1;
    coef_t   b2;
    coef_t   a1;
    coef_t   a2;
    thresh_t thresh;
  } coef_set_t;

endpackage

// File: rtl/core/biquad_iir_filter_unit.sv
// channel  | direction | handshake              | payload
// ---------+-----------+------------------------+---------------------------------------
// in_      | slave     | in_tvalid / in_tready  | tdata: sample[23:0]; tuser: restart
// out_     | master    | out_tvalid / out_tready| tdata: filtered[23:0]; tuser: clipped
// cfg_     | slave     | cfg_valid / cfg_ready  | cfg_index[2:0], cfg_data[27:0]
//
// one sample per cycle sustained while out_tready is high; a sample passes through the input
// register, then the five-tap multiply-add into the result register, before out_tvalid rises
// and the result transfer can take place
// the recursion closes with the history updating as the result register loads
// reset (rst_n low, synchronous) clears history, empties both registers and loads
// unit gain into b0 with all other coefficients and the flush threshold at zero
// with the output stalled the block still takes one more sample into its input
// register; cfg_ready is always high and writes take effect on the next cycle
module biquad_iir_filter_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  // sample[23:0]
  input  logic [biq_pkg::SAMPLE_BITS-1:0] in_tdata,
  // restart
  input  logic                         in_tuser,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // filtered[23:0]
  output logic [biq_pkg::SAMPLE_BITS-1:0] out_tdata,
  // clipped
  output logic                         out_tuser,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  biq_pkg::cfg_idx_t            cfg_index,
  input  logic [biq_pkg::COEF_W-1:0]   cfg_data
);
  import biq_pkg::*;

  coef_set_t coefs;

  // input register
  logic    stg_valid_r, stg_valid_nxt;
  sample_t stg_sample_r, stg_sample_nxt;
  logic    stg_restart_r, stg_restart_nxt;

  // result register
  logic    out_valid_r, out_valid_nxt;
  sample_t out_data_r, out_data_nxt;
  logic    out_clip_r, out_clip_nxt;

  sample_t y_calc;
  logic    clip_calc;
  logic    advance;
  logic    commit;
  logic    in_xfer;

  assign cfg_ready = 1'b1;

  biq_coef_regs u_coef_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .coefs    (coefs)
  );

  // result register can load when empty or being drained this cycle
  assign advance   = !out_valid_r || out_tready;
  assign commit    = stg_valid_r && advance;
  assign in_tready = !stg_valid_r || advance;
  assign in_xfer   = in_tvalid && in_tready;

  biq_datapath u_datapath (
    .clk     (clk),
    .rst_n   (rst_n),
    .coefs   (coefs),
    .x_in    (stg_sample_r),
    .restart (stg_restart_r),
    .commit  (commit),
    .y_out   (y_calc),
    .clip    (clip_calc)
  );

  always_comb begin
    stg_valid_nxt   = stg_valid_r;
    stg_sample_nxt  = stg_sample_r;
    stg_restart_nxt = stg_restart_r;
    if (in_xfer) begin
      stg_valid_nxt   = 1'b1;
      stg_sample_nxt  = in_tdata;
      stg_restart_nxt = in_tuser;
    end else if (commit) begin
      stg_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_clip_nxt  = out_clip_r;
    if (commit) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = y_calc;
      out_clip_nxt  = clip_calc;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      stg_valid_r <= stg_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    stg_sample_r  <= stg_sample_nxt;
    stg_restart_r <= stg_restart_nxt;
    out_data_r    <= out_data_nxt;
    out_clip_r    <= out_clip_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_clip_r;

  // a clipped result must sit at one of the range limits
  a_clip_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_clip_r) |-> (out_data_r == SAMPLE_MAX || out_data_r == SAMPLE_MIN))
    else $error("clipped result not at a range limit");

  // both registers full with the output stalled must stop input transfers
  a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (stg_valid_r && out_valid_r && !out_tready) |-> !in_tready)
    else $error("input accepted with no room");

  // a fresh result only appears after an occupied input register
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(stg_valid_r))
    else $error("result appeared without a staged sample");

endmodule

// File: rtl/core/biq_coef_regs.sv
module biq_coef_regs (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  biq_pkg::cfg_idx_t     wr_index,
  input  logic [biq_pkg::COEF_W-1:0] wr_data,
  output biq_pkg::coef_set_t    coefs
);
  import biq_pkg::*;

  coef_set_t coefs_r;
  coef_set_t coefs_nxt;

  always_comb begin
    coefs_nxt = coefs_r;
    if (wr_en) begin
      case (wr_index)
        REG_B0:     coefs_nxt.b0 = coef_t'(wr_data);
        REG_B1:     coefs_nxt.b1 = coef_t'(wr_data);
        REG_B2:     coefs_nxt.b2 = coef_t'(wr_data);
        REG_A1:     coefs_nxt.a1 = coef_t'(wr_data);
        REG_A2:     coefs_nxt.a2 = coef_t'(wr_data);
        REG_THRESH: coefs_nxt.thresh = wr_data[THRESH_W-1:0];
        default:    coefs_nxt = coefs_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coefs_r.b0     <= COEF_ONE;
      coefs_r.b1     <= '0;
      coefs_r.b2     <= '0;
      coefs_r.a1     <= '0;
      coefs_r.a2     <= '0;
      coefs_r.thresh <= '0;
    end else begin
      coefs_r <= coefs_nxt;
    end
  end

  assign coefs = coefs_r;

endmodule

// File: rtl/core/biq_datapath.sv
module biq_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  biq_pkg::coef_set_t coefs,
  input  biq_pkg::sample_t   x_in,
  input  logic               restart,
  input  logic               commit,
  output biq_pkg::sample_t   y_out,
  output logic               clip
);
  import biq_pkg::*;

  sample_t in_prev1_r, in_prev1_nxt;
  sample_t in_prev2_r, in_prev2_nxt;
  sample_t out_prev1_r, out_prev1_nxt;
  sample_t out_prev2_r, out_prev2_nxt;

  logic [SAMPLE_BITS-1:0] mag;
  logic    flush;
  sample_t x0;
  sample_t h_x1, h_x2, h_y1, h_y2;
  prod_t   p_b0, p_b1, p_b2, p_a1, p_a2;
  acc_t    acc;
  acc_t    acc_rnd;
  acc_t    shifted;
  logic    sat_hi, sat_lo;

  // magnitude as unsigned; the most negative sample maps to 2^(n-1)
  assign mag   = x_in[SAMPLE_BITS-1] ? ((~x_in) + SAMPLE_BITS'(1)) : x_in;
  assign flush = mag < {{(SAMPLE_BITS-THRESH_W){1'b0}}, coefs.thresh};
  assign x0    = flush ? '0 : x_in;

  assign h_x1 = restart ? '0 : in_prev1_r;
  assign h_x2 = restart ? '0 : in_prev2_r;
  assign h_y1 = restart ? '0 : out_prev1_r;
  assign h_y2 = restart ? '0 : out_prev2_r;

  assign p_b0 = coefs.b0 * x0;
  assign p_b1 = coefs.b1 * h_x1;
  assign p_b2 = coefs.b2 * h_x2;
  assign p_a1 = coefs.a1 * h_y1;
  assign p_a2 = coefs.a2 * h_y2;

  assign acc = acc_t'(p_b0) + acc_t'(p_b1) + acc_t'(p_b2)
             - acc_t'(p_a1) - acc_t'(p_a2);

  // round half up, then floor shift
  assign acc_rnd = acc + ROUND_HALF;
  assign shifted = acc_rnd >>> COEF_FRAC_BITS;

  assign sat_hi = shifted > ACC_SMAX;
  assign sat_lo = shifted < ACC_SMIN;
  assign clip   = sat_hi || sat_lo;
  assign y_out  = sat_hi ? SAMPLE_MAX :
                  sat_lo ? SAMPLE_MIN : shifted[SAMPLE_BITS-1:0];

  always_comb begin
    in_prev1_nxt  = in_prev1_r;
    in_prev2_nxt  = in_prev2_r;
    out_prev1_nxt = out_prev1_r;
    out_prev2_nxt = out_prev2_r;
    if (commit) begin
      in_prev2_nxt  = h_x1;
      in_prev1_nxt  = x0;
      out_prev2_nxt = h_y1;
      out_prev1_nxt = y_out;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_prev1_r  <= '0;
      in_prev2_r  <= '0;
      out_prev1_r <= '0;
      out_prev2_r <= '0;
    end else begin
      in_prev1_r  <= in_prev1_nxt;
      in_prev2_r  <= in_prev2_nxt;
      out_prev1_r <= out_prev1_nxt;
      out_prev2_r <= out_prev2_nxt;
    end
  end

  // a restarted item leaves the older history entries cleared
  a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && restart) |=> (in_prev2_r == '0 && out_prev2_r == '0))
    else $error("restart did not clear older history");

  // the output history holds the saturated result of the last committed item
  a_hist_is_output: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> (out_prev1_r == $past(y_out)))
    else $error("output history does not track the committed result");

  // a flushed sample enters history as zero
  a_flush_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && flush) |=> (in_prev1_r == '0))
    else $error("flushed sample stored nonzero");

endmodule

// File: tb/biquad_iir_filter_unit_tb.sv
module biquad_iir_filter_unit_tb;
  import biq_pkg::*;

  localparam int RUN_LIMIT = 400000;
  localparam int PHASES = 15;
  localparam int PHASE_ITEMS = 110;

  // indexes past the last register, writes there must be dropped
  localparam cfg_idx_t IDX_SPARE_LO = REG_THRESH + cfg_idx_t'(1);
  localparam cfg_idx_t IDX_SPARE_HI = '1;

  localparam coef_t COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
  localparam coef_t COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};
  localparam coef_t COEF_HALF = COEF_ONE >>> 1;

  typedef struct {
    sample_t filtered;
    logic    clipped;
  } filt_result_t;

  logic clk;
  logic rst_n;
  logic [SAMPLE_BITS-1:0] in_tdata;
  logic in_tuser;
  logic in_tvalid;
  logic in_tready;
  logic [SAMPLE_BITS-1:0] out_tdata;
  logic out_tuser;
  logic out_tvalid;
  logic out_tready;
  logic cfg_valid;
  logic cfg_ready;
  cfg_idx_t cfg_index;
  logic [COEF_W-1:0] cfg_data;

  // shadow copy of the coefficient set and the filter history
  coef_t tap_b0, tap_b1, tap_b2, fb_a1, fb_a2;
  thresh_t flush_level;
  sample_t hist_x1, hist_x2, hist_y1, hist_y2;

  filt_result_t pending_outputs[$];
  bit pace_on;
  int mismatch_count;
  int samples_sent;
  int results_seen;
  int clip_seen;
  int setting_count;
  int cycle_count;

  biquad_iir_filter_unit uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic void reset_filter_state();
    tap_b0 = COEF_ONE;
    tap_b1 = '0;
    tap_b2 = '0;
    fb_a1 = '0;
    fb_a2 = '0;
    flush_level = '0;
    hist_x1 = '0;
    hist_x2 = '0;
    hist_y1 = '0;
    hist_y2 = '0;
  endfunction

  function automatic void apply_reg(cfg_idx_t idx, logic [COEF_W-1:0] val);
    case (idx)
      REG_B0: tap_b0 = coef_t'(val);
      REG_B1: tap_b1 = coef_t'(val);
      REG_B2: tap_b2 = coef_t'(val);
      REG_A1: fb_a1 = coef_t'(val);
      REG_A2: fb_a2 = coef_t'(val);
      REG_THRESH: flush_level = thresh_t'(val);
      default: ;
    endcase
  endfunction

  // direct form I step: clear on restart, flush, five taps, round half up, saturate, shift history
  function automatic filt_result_t biquad_next(sample_t x_in, logic restart);
    longint x0, mag, acc, y;
    filt_result_t r;
    if (restart) begin
      hist_x1 = '0;
      hist_x2 = '0;
      hist_y1 = '0;
      hist_y2 = '0;
    end
    x0 = x_in;
    mag = (x0 < 0) ? -x0 : x0;
    if (mag < longint'(flush_level))
      x0 = 0;
    acc = longint'(tap_b0) * x0 + longint'(tap_b1) * longint'(hist_x1)
        + longint'(tap_b2) * longint'(hist_x2)
        - longint'(fb_a1) * longint'(hist_y1) - longint'(fb_a2) * longint'(hist_y2);
    acc = acc + (longint'(1) << (COEF_FRAC_BITS - 1));
    y = acc >>> COEF_FRAC_BITS;
    r.clipped = 1'b0;
    if (y > longint'(SAMPLE_MAX)) begin
      y = SAMPLE_MAX;
      r.clipped = 1'b1;
    end else if (y < longint'(SAMPLE_MIN)) begin
      y = SAMPLE_MIN;
      r.clipped = 1'b1;
    end
    r.filtered = sample_t'(y);
    hist_x2 = hist_x1;
    hist_x1 = sample_t'(x0);
    hist_y2 = hist_y1;
    hist_y1 = r.filtered;
    return r;
  endfunction

  // one sample transfer; valid stays up across back-to-back items
  task automatic push_sample(input sample_t s, input logic restart);
    int gap;
    gap = pace_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= s;
    in_tuser <= restart;
    do @(posedge clk); while (!in_tready);
    pending_outputs.push_back(biquad_next(s, restart));
    samples_sent++;
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_outputs.size() > 0) @(posedge clk);
  endtask

  // writes all six registers plus one spare index, only while the filter is idle
  task automatic load_filter(input coef_t b0, b1, b2, a1, a2, input thresh_t th);
    cfg_idx_t idx [7];
    logic [COEF_W-1:0] val [7];
    wait_idle();
    idx = '{REG_B0, REG_B1, REG_B2, REG_A1, REG_A2, REG_THRESH,
            $urandom_range(0, 1) ? IDX_SPARE_HI : IDX_SPARE_LO};
    val = '{b0, b1, b2, a1, a2, {{(COEF_W-THRESH_W){1'b0}}, th},
            COEF_W'($urandom())};
    for (int i = 0; i < 7; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= val[i];
      do @(posedge clk); while (!cfg_ready);
      apply_reg(idx[i], val[i]);
    end
    cfg_valid <= 1'b0;
    setting_count++;
  endtask

  function automatic coef_t rand_coef_span(int span);
    return coef_t'(int'($urandom_range(0, 2 * span)) - span);
  endfunction

  function automatic sample_t rand_sample();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: return SAMPLE_MAX;
          1: return SAMPLE_MIN;
          2: return '0;
          default: return '1;
        endcase
      end
      1, 2: return sample_t'(int'($urandom_range(0, 600)) - 300);
      3: return sample_t'($urandom());
      default: return sample_t'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
    endcase
  endfunction

  // output side: random stall before each result, or always ready
  initial begin
    int gap;
    out_tready = 1'b0;
    forever begin
      gap = pace_on ? $urandom_range(0, 3) : 0;
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // compare every result transfer against the oldest prediction
  always @(posedge clk) begin
    filt_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (out_tuser) clip_seen++;
      if (pending_outputs.size() == 0) begin
        $error("result transfer with nothing expected: filtered %0d clipped %0b",
               $signed(out_tdata), out_tuser);
        mismatch_count++;
      end else begin
        want = pending_outputs.pop_front();
        if (out_tdata !== want.filtered) begin
          $error("filtered: expected %0d, got %0d", want.filtered, $signed(out_tdata));
          mismatch_count++;
        end
        if (out_tuser !== want.clipped) begin
          $error("clipped: expected %0b, got %0b", want.clipped, out_tuser);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > RUN_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_outputs.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // unity gain straight after reset
  task automatic test_reset_defaults();
    push_sample(SAMPLE_MAX, 1'b0);
    push_sample(SAMPLE_MIN, 1'b0);
    push_sample('0, 1'b1);
    push_sample(sample_t'(1), 1'b0);
    push_sample('1, 1'b0);
    push_sample(sample_t'(24'h555555), 1'b0);
    push_sample(sample_t'(24'haaaaaa), 1'b1);
    wait_idle();
  endtask

  // magnitudes just under, at and above the threshold; most negative sample is kept
  task automatic test_flush_threshold();
    load_filter(COEF_ONE, COEF_HALF, '0, '0, '0, thresh_t'(255));
    push_sample(sample_t'(254), 1'b1);
    push_sample(sample_t'(-254), 1'b0);
    push_sample(sample_t'(255), 1'b0);
    push_sample(sample_t'(-255), 1'b0);
    push_sample(SAMPLE_MIN, 1'b0);
    push_sample(sample_t'(1), 1'b0);
    wait_idle();
  endtask

  // ties round toward plus infinity; large gains saturate both ways
  task automatic test_round_and_clip();
    load_filter(COEF_HALF, '0, '0, '0, '0, '0);
    push_sample(sample_t'(1), 1'b1);
    push_sample(sample_t'(-1), 1'b0);
    push_sample(sample_t'(3), 1'b0);
    push_sample(sample_t'(-3), 1'b0);
    // saturated output feeds back through a negative a1
    load_filter(COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX, '0);
    push_sample(SAMPLE_MAX, 1'b1);
    push_sample(SAMPLE_MIN, 1'b0);
    push_sample(sample_t'(100), 1'b0);
    push_sample('0, 1'b1);
    push_sample(sample_t'(5), 1'b0);
    wait_idle();
  endtask

  // random coefficient sets, each followed by a restart and a run of samples
  task automatic test_random_phases();
    coef_t b0, b1, b2, a1, a2;
    thresh_t th;
    for (int p = 0; p < PHASES; p++) begin
      case (p % 3)
        0: begin
          b0 = coef_t'($urandom());
          b1 = coef_t'($urandom());
          b2 = coef_t'($urandom());
          a1 = coef_t'($urandom());
          a2 = coef_t'($urandom());
          th = thresh_t'($urandom());
        end
        1: begin
          // roughly stable filters so the history stays in range
          b0 = rand_coef_span(1 << 23);
          b1 = rand_coef_span(1 << 23);
          b2 = rand_coef_span(1 << 23);
          a1 = rand_coef_span(31000000);
          a2 = rand_coef_span(15000000);
          th = thresh_t'($urandom_range(0, 16));
        end
        default: begin
          if ($urandom_range(0, 1)) begin
            b0 = COEF_MAX; b1 = COEF_MAX; b2 = COEF_MAX; a1 = COEF_MAX; a2 = COEF_MAX;
          end else begin
            b0 = COEF_MIN; b1 = COEF_MIN; b2 = COEF_MIN; a1 = COEF_MIN; a2 = COEF_MIN;
          end
          th = $urandom_range(0, 1) ? thresh_t'(255) : thresh_t'(0);
        end
      endcase
      load_filter(b0, b1, b2, a1, a2, th);
      // every fourth phase runs with no gaps on either side
      pace_on = (p % 4 != 3);
      for (int i = 0; i < PHASE_ITEMS; i++)
        push_sample(rand_sample(), (i == 0) || ($urandom_range(0, 19) == 0));
      pace_on = 1'b1;
    end
    wait_idle();
  endtask

  initial begin
    rst_n = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    in_tvalid = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_B0;
    cfg_data = '0;
    pace_on = 1'b1;
    mismatch_count = 0;
    samples_sent = 0;
    results_seen = 0;
    clip_seen = 0;
    setting_count = 0;
    cycle_count = 0;
    reset_filter_state();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_flush_threshold();
    test_round_and_clip();
    test_random_phases();

    // leave some slack for stray transfers
    repeat (8) @(posedge clk);
    if (pending_outputs.size() != 0) begin
      $error("%0d expected results never arrived", pending_outputs.size());
      mismatch_count++;
    end
    $display("%0d samples filtered over %0d coefficient loads", samples_sent, setting_count);
    $display("%0d results checked, %0d of them saturated", results_seen, clip_seen);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: biquad_iir_filter_unit.f
rtl/core/biq_pkg.sv
rtl/core/biq_coef_regs.sv
rtl/core/biq_datapath.sv
rtl/core/biquad_iir_filter_unit.sv
tb/biquad_iir_filter_unit_tb.sv
